// ===== src/clp_pkg.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// clp_pkg: shared types and constants
// Character codes, parse phases, result kinds and per-port state records
// for the grip command line parser.
// ---------------------------------------------------------------------------
package clp_pkg;

  localparam int unsigned LINE_CAPACITY = 24;
  localparam int unsigned LEN_W         = $clog2(LINE_CAPACITY);
  localparam int unsigned NUM_PORTS     = 2;
  localparam int unsigned OPEN_W        = 20;

  localparam logic [OPEN_W-1:0] OPENING_MAX     = 20'hFFFFF;
  localparam logic [OPEN_W-1:0] MAX_OPENING_RST = 20'd25000;
  localparam logic [LEN_W-1:0]  LEN_LIMIT       = LEN_W'(LINE_CAPACITY - 1);

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_POINT = 8'h2E;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_G     = 8'h47;
  localparam logic [7:0] CH_I     = 8'h49;
  localparam logic [7:0] CH_P     = 8'h50;
  localparam logic [7:0] CH_R     = 8'h52;

  typedef enum logic [3:0] {
    PH_LEAD, PH_R, PH_REL, PH_G, PH_GR, PH_GRI, PH_GRIP,
    PH_SP, PH_INT, PH_FRAC, PH_DONE, PH_BAD, PH_VOID
  } phase_t;

  typedef enum logic [1:0] {
    KIND_RELEASE, KIND_GRIP, KIND_BAD, KIND_RANGE
  } kind_t;

  typedef struct packed {
    phase_t            phase;
    logic [OPEN_W-1:0] accum;
    logic [1:0]        frac;
    logic              sat;
  } parse_st_t;

  typedef struct packed {
    logic              valid;
    kind_t             kind;
    logic [OPEN_W-1:0] opening;
  } result_t;

endpackage

`default_nettype wire

// ===== src/clp_line_step.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// clp_line_step: one-byte line update
// Combinational next-state and result logic for one received byte applied
// to the line length and parse state of its port.
// ---------------------------------------------------------------------------
module clp_line_step
  import clp_pkg::*;
(
  input  wire logic [7:0]        rx_byte,
  input  wire logic [LEN_W-1:0]  len_cur,
  input  wire parse_st_t         st_cur,
  input  wire logic [OPEN_W-1:0] max_opening,
  output logic [LEN_W-1:0]       len_nxt,
  output parse_st_t              st_nxt,
  output result_t                res
);

  parse_st_t         st_clear;
  parse_st_t         st_fed;
  logic              is_digit;
  logic [23:0]       acc_t;
  logic              acc_ovf;
  logic [29:0]       scaled;
  logic [OPEN_W-1:0] dig_acc;
  logic              dig_sat;

  assign st_clear = '{phase: PH_LEAD, accum: '0, frac: 2'd0, sat: 1'b0};
  assign is_digit = (rx_byte >= CH_ZERO) && (rx_byte <= CH_NINE);

  // Accumulate one decimal digit, clamping at the field maximum.
  assign acc_t   = 24'(st_cur.accum) * 24'd10 + 24'(rx_byte[3:0]);
  assign acc_ovf = st_cur.sat || (acc_t > 24'(OPENING_MAX));
  assign dig_acc = acc_ovf ? OPENING_MAX : acc_t[OPEN_W-1:0];
  assign dig_sat = acc_ovf;

  always_comb begin
    st_fed = st_cur;
    if (rx_byte == CH_NUL) begin
      // A NUL byte freezes the text parsed so far.
      unique case (st_cur.phase)
        PH_LEAD: st_fed.phase = PH_VOID;
        PH_R:    st_fed.phase = PH_REL;
        PH_INT, PH_FRAC: st_fed.phase = PH_DONE;
        PH_G, PH_GR, PH_GRI, PH_GRIP, PH_SP: st_fed.phase = PH_BAD;
        default: st_fed.phase = st_cur.phase;
      endcase
    end else begin
      unique case (st_cur.phase)
        PH_LEAD: begin
          if (rx_byte != CH_SPACE) begin
            st_fed.phase = (rx_byte == CH_R) ? PH_R : (rx_byte == CH_G) ? PH_G : PH_BAD;
          end
        end
        PH_R:    st_fed.phase = (rx_byte == CH_SPACE) ? PH_REL : PH_BAD;
        PH_G:    st_fed.phase = (rx_byte == CH_SPACE) ? PH_SP :
                                (rx_byte == CH_R) ? PH_GR : PH_BAD;
        PH_GR:   st_fed.phase = (rx_byte == CH_I) ? PH_GRI : PH_BAD;
        PH_GRI:  st_fed.phase = (rx_byte == CH_P) ? PH_GRIP : PH_BAD;
        PH_GRIP: st_fed.phase = (rx_byte == CH_SPACE) ? PH_SP : PH_BAD;
        PH_SP: begin
          if (is_digit) begin
            st_fed.accum = dig_acc;
            st_fed.sat   = dig_sat;
            st_fed.phase = PH_INT;
          end else if (rx_byte == CH_POINT) begin
            st_fed.phase = PH_FRAC;
          end else if (rx_byte != CH_SPACE) begin
            st_fed.phase = PH_BAD;
          end
        end
        PH_INT: begin
          if (is_digit) begin
            st_fed.accum = dig_acc;
            st_fed.sat   = dig_sat;
          end else if (rx_byte == CH_POINT) begin
            st_fed.phase = PH_FRAC;
          end else begin
            st_fed.phase = PH_DONE;
          end
        end
        PH_FRAC: begin
          if (is_digit) begin
            // Only three fraction digits are kept; later ones are ignored.
            if (st_cur.frac != 2'd3) begin
              st_fed.accum = dig_acc;
              st_fed.sat   = dig_sat;
              st_fed.frac  = st_cur.frac + 2'd1;
            end
          end else begin
            st_fed.phase = PH_DONE;
          end
        end
        default: st_fed.phase = st_cur.phase;
      endcase
    end
  end

  // Scale the gathered digits to micrometres.
  always_comb begin
    case (st_cur.frac)
      2'd0:    scaled = 30'(st_cur.accum) * 30'd1000;
      2'd1:    scaled = 30'(st_cur.accum) * 30'd100;
      2'd2:    scaled = 30'(st_cur.accum) * 30'd10;
      default: scaled = 30'(st_cur.accum);
    endcase
  end

  always_comb begin
    res     = '{valid: 1'b0, kind: KIND_BAD, opening: '0};
    len_nxt = len_cur;
    st_nxt  = st_cur;
    if ((rx_byte == CH_LF) || (rx_byte == CH_CR)) begin
      if (len_cur != '0) begin
        len_nxt = '0;
        st_nxt  = st_clear;
        unique case (st_cur.phase)
          PH_LEAD, PH_VOID: res.valid = 1'b0;
          PH_R, PH_REL: begin
            res.valid = 1'b1;
            res.kind  = KIND_RELEASE;
          end
          PH_INT, PH_FRAC, PH_DONE: begin
            res.valid = 1'b1;
            if (st_cur.sat || (scaled > 30'(OPENING_MAX))) begin
              res.kind    = KIND_RANGE;
              res.opening = OPENING_MAX;
            end else begin
              res.opening = scaled[OPEN_W-1:0];
              res.kind    = (scaled[OPEN_W-1:0] > max_opening) ? KIND_RANGE : KIND_GRIP;
            end
          end
          default: begin
            res.valid = 1'b1;
            res.kind  = KIND_BAD;
          end
        endcase
      end
    end else if (len_cur >= LEN_LIMIT) begin
      // Overflowing byte is dropped and the line starts over.
      len_nxt = '0;
      st_nxt  = st_clear;
    end else begin
      len_nxt = len_cur + LEN_W'(1);
      st_nxt  = st_fed;
    end
  end

endmodule

`default_nettype wire

// ===== src/grip_command_line_parser_core.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// grip_command_line_parser_core: two-port grip command line parser
// Assembles and parses command lines from two serial ports, one byte per
// request, and reports release, grip, bad command or out-of-range results.
// ---------------------------------------------------------------------------
// Each accepted byte passes an input register, combinational parse logic that
// updates its port's line state, and a result register; a line-ending byte's
// result is loaded into the result register as that byte leaves the input
// register. Throughput is one byte per cycle while results are taken; a stalled
// result holds back the parse stage and then the input.
module grip_command_line_parser_core
  import clp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] rx_byte
  input  wire logic [0:0]  in_tuser,   // [0] port_id
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [23:0]      out_tdata,  // [19:0] opening_um, [23:20] zero
  output logic [2:0]       out_tuser,  // [1:0] result_kind, [2] from_port
  input  wire logic        cfg_we,
  input  wire logic [19:0] cfg_wdata   // [19:0] max_opening_um
);

  logic              in_valid_r;
  logic [7:0]        in_byte_r;
  logic              in_port_r;
  logic              fire;
  logic [OPEN_W-1:0] max_opening_r;

  logic [LEN_W-1:0]  len_r  [NUM_PORTS];
  parse_st_t         pst_r  [NUM_PORTS];
  logic [LEN_W-1:0]  len_nxt;
  parse_st_t         pst_nxt;
  result_t           res;

  logic              out_valid_r;
  kind_t             out_kind_r;
  logic [OPEN_W-1:0] out_open_r;
  logic              out_port_r;

  assign fire      = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_byte_r <= in_tdata;
      in_port_r <= in_tuser[0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_opening_r <= MAX_OPENING_RST;
    end else if (cfg_we) begin
      max_opening_r <= cfg_wdata;
    end
  end

  clp_line_step u_step (
    .rx_byte     (in_byte_r),
    .len_cur     (len_r[in_port_r]),
    .st_cur      (pst_r[in_port_r]),
    .max_opening (max_opening_r),
    .len_nxt     (len_nxt),
    .st_nxt      (pst_nxt),
    .res         (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_PORTS; i++) begin
        len_r[i] <= '0;
        pst_r[i] <= '{phase: PH_LEAD, accum: '0, frac: 2'd0, sat: 1'b0};
      end
    end else if (fire) begin
      len_r[in_port_r] <= len_nxt;
      pst_r[in_port_r] <= pst_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire && res.valid) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && res.valid) begin
      out_kind_r <= res.kind;
      out_open_r <= res.opening;
      out_port_r <= in_port_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'd0, out_open_r};
  assign out_tuser  = {out_port_r, out_kind_r};

  // A line never holds more than capacity minus one bytes.
  a_len0_bound: assert property (@(posedge clk) disable iff (!rst_n)
    len_r[0] <= LEN_LIMIT) else $error("port 0 line length overflow");
  a_len1_bound: assert property (@(posedge clk) disable iff (!rst_n)
    len_r[1] <= LEN_LIMIT) else $error("port 1 line length overflow");
  a_release_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_kind_r == KIND_RELEASE || out_kind_r == KIND_BAD))
      |-> (out_open_r == '0)) else $error("nonzero opening on release or bad command");
  a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !fire |=> ($stable(len_r[0]) && $stable(len_r[1])))
    else $error("line state changed without a request");

endmodule

`default_nettype wire

// ===== tb/tb_grip_command_line_parser_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_grip_command_line_parser_core
// Self-checking testbench for the two-port grip command line parser. Command
// lines, well-formed and broken, are streamed on both ports under varying
// flow control and opening limits. Every accepted result is compared with
// the one predicted by a behavioral copy of the parser.
// ----------------------------------------------------------------------------
module tb_grip_command_line_parser_core;
  import clp_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam int PHASE_BYTES = 300;

  typedef struct {
    kind_t             kind;
    logic [OPEN_W-1:0] opening;
    logic              port;
  } line_result_t;

  // Keeps a per-port copy of the line state and the results still owed.
  class line_scoreboard;
    logic [OPEN_W-1:0] max_um;
    int unsigned       len [NUM_PORTS];
    phase_t            phase [NUM_PORTS];
    logic [OPEN_W-1:0] accum [NUM_PORTS];
    int unsigned       frac [NUM_PORTS];
    bit                sat [NUM_PORTS];
    line_result_t      pending [$];
    int                errors;
    int                kind_seen [4];

    function new();
      max_um = MAX_OPENING_RST;
      errors = 0;
      foreach (kind_seen[k]) kind_seen[k] = 0;
      for (int p = 0; p < NUM_PORTS; p++) begin
        len[p] = 0;
        restart(p);
      end
    endfunction

    function void restart(int p);
      phase[p] = PH_LEAD;
      accum[p] = '0;
      frac[p]  = 0;
      sat[p]   = 1'b0;
    endfunction

    function void push_digit(int p, logic [7:0] c);
      longint unsigned t;
      t = longint'(accum[p]) * 10 + longint'(c - CH_ZERO);
      if (sat[p] || t > OPENING_MAX) begin
        sat[p]   = 1'b1;
        accum[p] = OPENING_MAX;
      end else begin
        accum[p] = t[OPEN_W-1:0];
      end
    endfunction

    function void advance_parse(int p, logic [7:0] c);
      phase_t ph;
      bit     digit;
      ph    = phase[p];
      digit = (c >= CH_ZERO) && (c <= CH_NINE);
      if (c == CH_NUL) begin
        // A NUL freezes the line: whatever was parsed so far decides it.
        case (ph)
          PH_LEAD: ph = PH_VOID;
          PH_R: ph = PH_REL;
          PH_INT, PH_FRAC: ph = PH_DONE;
          PH_G, PH_GR, PH_GRI, PH_GRIP, PH_SP: ph = PH_BAD;
          default: ;
        endcase
      end else begin
        case (ph)
          PH_LEAD: begin
            if (c == CH_R) ph = PH_R;
            else if (c == CH_G) ph = PH_G;
            else if (c != CH_SPACE) ph = PH_BAD;
          end
          PH_R: ph = (c == CH_SPACE) ? PH_REL : PH_BAD;
          PH_G: begin
            if (c == CH_SPACE) ph = PH_SP;
            else if (c == CH_R) ph = PH_GR;
            else ph = PH_BAD;
          end
          PH_GR: ph = (c == CH_I) ? PH_GRI : PH_BAD;
          PH_GRI: ph = (c == CH_P) ? PH_GRIP : PH_BAD;
          PH_GRIP: ph = (c == CH_SPACE) ? PH_SP : PH_BAD;
          PH_SP: begin
            if (digit) begin
              push_digit(p, c);
              ph = PH_INT;
            end else if (c == CH_POINT) begin
              ph = PH_FRAC;
            end else if (c != CH_SPACE) begin
              ph = PH_BAD;
            end
          end
          PH_INT: begin
            if (digit) push_digit(p, c);
            else if (c == CH_POINT) ph = PH_FRAC;
            else ph = PH_DONE;
          end
          PH_FRAC: begin
            if (!digit) begin
              ph = PH_DONE;
            end else if (frac[p] < 3) begin
              push_digit(p, c);
              frac[p]++;
            end
          end
          default: ;
        endcase
      end
      phase[p] = ph;
    endfunction

    function void close_line(int p);
      line_result_t    r;
      longint unsigned v;
      if (phase[p] == PH_LEAD || phase[p] == PH_VOID) return;
      r.port    = p[0];
      r.opening = '0;
      case (phase[p])
        PH_R, PH_REL: r.kind = KIND_RELEASE;
        PH_INT, PH_FRAC, PH_DONE: begin
          v = accum[p];
          for (int k = frac[p]; k < 3; k++) v = v * 10;
          if (sat[p] || v > OPENING_MAX) begin
            r.opening = OPENING_MAX;
            r.kind    = KIND_RANGE;
          end else begin
            r.opening = v[OPEN_W-1:0];
            r.kind    = (v > max_um) ? KIND_RANGE : KIND_GRIP;
          end
        end
        default: r.kind = KIND_BAD;
      endcase
      pending.push_back(r);
    endfunction

    function void note_request(logic [7:0] c, logic port);
      int p;
      p = port;
      if (c == CH_LF || c == CH_CR) begin
        if (len[p] > 0) begin
          close_line(p);
          len[p] = 0;
          restart(p);
        end
      end else if (len[p] >= LINE_CAPACITY - 1) begin
        // The byte that would overflow the line is dropped and the line restarts.
        len[p] = 0;
        restart(p);
      end else begin
        len[p]++;
        advance_parse(p, c);
      end
    endfunction

    function void check_result(logic [23:0] tdata, logic [2:0] tuser);
      line_result_t want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result, kind %0d opening %0d port %0d", $time,
                 tuser[1:0], tdata, tuser[2]);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (tuser[1:0] !== want.kind) begin
        $display("%0t: result kind mismatch, expected %0d, actual %0d", $time,
                 want.kind, tuser[1:0]);
        errors++;
      end
      if (tdata !== {4'b0, want.opening}) begin
        $display("%0t: opening mismatch, expected %0d, actual %0d", $time,
                 want.opening, tdata);
        errors++;
      end
      if (tuser[2] !== want.port) begin
        $display("%0t: port mismatch, expected %0d, actual %0d", $time,
                 want.port, tuser[2]);
        errors++;
      end
      kind_seen[want.kind]++;
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;     // [7:0] rx_byte
  logic [0:0]  in_tuser = '0;     // [0] port_id
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;         // [19:0] opening_um, [23:20] zero
  logic [2:0]  out_tuser;         // [1:0] result_kind, [2] from_port
  logic        cfg_we = 1'b0;
  logic [19:0] cfg_wdata = '0;    // [19:0] max_opening_um

  line_scoreboard    sb;
  int                send_idle_pct = 0;
  int                recv_idle_pct = 0;
  int                bytes_in = 0;
  int                quiet_cycles = 0;
  logic [OPEN_W-1:0] limits [6];

  grip_command_line_parser_core i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) sb.check_result(out_tdata, out_tuser);
      if (in_tvalid && in_tready) begin
        sb.note_request(in_tdata, in_tuser[0]);
        bytes_in++;
      end
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("%0t: watchdog expired with %0d results outstanding", $time,
                 sb.pending.size());
        $display("tb_grip_command_line_parser_core failed");
        $finish;
      end
    end
  end

  task automatic send_byte(logic [7:0] b, logic port);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid   <= 1'b1;
    in_tdata    <= b;
    in_tuser[0] <= port;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic send_text(string s, logic port);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], port);
  endtask

  // The limit only changes once every owed result is out and the pipeline
  // has had time to drain any bytes that produce nothing.
  task automatic write_max(logic [OPEN_W-1:0] v);
    in_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    sb.max_um = v;
  endtask

  function automatic void put_decimal(ref logic [7:0] text[$], input longint unsigned v,
                                      input int width);
    logic [7:0] digs[$];
    do begin
      digs.push_front(CH_ZERO + 8'(v % 10));
      v = v / 10;
    end while (v != 0);
    while (digs.size() < width) digs.push_front(CH_ZERO);
    foreach (digs[i]) text.push_back(digs[i]);
  endfunction

  function automatic void build_line(ref logic [7:0] text[$], input logic [OPEN_W-1:0] limit);
    int              pick;
    int              n;
    longint unsigned v;
    pick = $urandom_range(0, 99);
    if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 3)) text.push_back(CH_SPACE);
    if (pick < 60) begin
      text.push_back(CH_G);
      if ($urandom_range(0, 1)) begin
        text.push_back(CH_R);
        text.push_back(CH_I);
        text.push_back(CH_P);
      end
      repeat ($urandom_range(1, 2)) text.push_back(CH_SPACE);
      if ($urandom_range(0, 3) == 0) begin
        // Land on the limit or one micrometre to either side of it.
        v = longint'(limit) + $urandom_range(0, 2);
        v = (v == 0) ? 0 : v - 1;
        put_decimal(text, v / 1000, 1);
        text.push_back(CH_POINT);
        put_decimal(text, v % 1000, 3);
      end else begin
        n = $urandom_range(0, 7);
        repeat (n) text.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
        if (n == 0 || $urandom_range(0, 1)) begin
          text.push_back(CH_POINT);
          repeat ($urandom_range(0, 5)) text.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
        end
      end
      if ($urandom_range(0, 4) == 0) text.push_back(8'($urandom_range(33, 126)));
      if ($urandom_range(0, 19) == 0) text.insert($urandom_range(0, text.size()), CH_NUL);
      if (pick >= 45) text[$urandom_range(0, text.size() - 1)] = 8'($urandom_range(32, 126));
    end else if (pick < 75) begin
      text.push_back(CH_R);
      if ($urandom_range(0, 1)) begin
        text.push_back(CH_SPACE);
        repeat ($urandom_range(0, 4)) text.push_back(8'($urandom_range(33, 126)));
      end else if ($urandom_range(0, 3) == 0) begin
        text.push_back(8'($urandom_range(33, 126)));
      end
    end else if (pick < 90) begin
      repeat ($urandom_range(0, 12)) text.push_back(8'($urandom_range(0, 255)));
    end else if (pick < 95) begin
      repeat ($urandom_range(20, 40)) text.push_back(8'($urandom_range(32, 126)));
    end
    text.push_back($urandom_range(0, 1) ? CH_CR : CH_LF);
    if ($urandom_range(0, 9) == 0) text.push_back(CH_LF);
  endfunction

  task automatic random_traffic(int count);
    logic [7:0] text_a[$];
    logic [7:0] text_b[$];
    int         sent;
    sent = 0;
    while (sent < count) begin
      text_a.delete();
      text_b.delete();
      build_line(text_a, sb.max_um);
      build_line(text_b, sb.max_um);
      sent += text_a.size() + text_b.size();
      if ($urandom_range(0, 1)) begin
        foreach (text_a[i]) send_byte(text_a[i], 1'b0);
        foreach (text_b[i]) send_byte(text_b[i], 1'b1);
      end else begin
        while (text_a.size() + text_b.size() != 0) begin
          if (text_b.size() == 0 || (text_a.size() != 0 && $urandom_range(0, 1)))
            send_byte(text_a.pop_front(), 1'b0);
          else
            send_byte(text_b.pop_front(), 1'b1);
        end
      end
    end
  endtask

  initial begin
    sb = new();
    limits[0] = OPENING_MAX;
    limits[1] = '0;
    limits[2] = 20'($urandom_range(1000, 200000));
    limits[3] = 20'd999;
    limits[4] = 20'($urandom);
    limits[5] = MAX_OPENING_RST;
    send_idle_pct = 22;
    recv_idle_pct = 47;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Directed lines at the reset limit of 25 mm.
    send_text("R\r", 1'b0);
    send_text("R go\n", 1'b1);
    send_text("  G 12.5\r", 1'b0);
    send_text("GRIP 25\n", 1'b0);
    send_text("G 25.001\r", 1'b1);
    send_text("G   1.23456\n", 1'b0);
    send_text("G .\rGRIP 5.\nG 0\r", 1'b1);
    send_text("G 7e3\rG 99999999\n", 1'b0);
    send_text("G\rG5\rGRIPx 1\r", 1'b0);
    send_byte(8'hFF, 1'b1);
    send_text("\r\r   \n", 1'b1);
    send_text("G 3", 1'b1);
    send_byte(CH_NUL, 1'b1);
    send_text("xx\r", 1'b1);
    send_byte(CH_NUL, 1'b0);
    send_byte(CH_LF, 1'b0);
    repeat (LINE_CAPACITY - 1) send_byte(CH_P, 1'b0);
    send_text("ZR\r", 1'b0);
    send_byte(CH_G, 1'b0);
    send_byte(CH_R, 1'b1);
    send_text(" 8", 1'b0);
    send_byte(CH_CR, 1'b1);
    send_byte(CH_LF, 1'b0);

    for (int mode = 0; mode < 3; mode++) begin
      send_idle_pct = (mode == 0) ? 22 : (mode == 1) ? 47 : 0;
      recv_idle_pct = (mode == 0) ? 47 : (mode == 1) ? 22 : 0;
      for (int half = 0; half < 2; half++) begin
        write_max(limits[2 * mode + half]);
        random_traffic(PHASE_BYTES);
      end
    end

    in_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    $display("Streamed %0d bytes on two ports; results: %0d release, %0d grip, %0d bad, %0d range.",
             bytes_in, sb.kind_seen[KIND_RELEASE], sb.kind_seen[KIND_GRIP],
             sb.kind_seen[KIND_BAD], sb.kind_seen[KIND_RANGE]);
    $display("Opening limit swept through zero, full scale and four other values.");
    if (sb.errors == 0) begin
      $display("tb_grip_command_line_parser_core passed");
    end else begin
      $display("tb_grip_command_line_parser_core failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/clp_pkg.sv
src/clp_line_step.sv
src/grip_command_line_parser_core.sv
tb/tb_grip_command_line_parser_core.sv
